// ----- hdl/sbtc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbtc_pkg - shared types and constants of the six-bit text codec
// Job descriptor passed from the front end to the back end through the job
// queue, register map and fixed codec constants.
// ----------------------------------------------------------------------------
package sbtc_pkg;

   // Symbol offset: a 6-bit value v travels as v + SYM_OFFSET
   localparam logic [7:0] SYM_OFFSET = 8'h3c;

   // Default cap on output words per message
   localparam int DEF_MAX_OUTPUT = 65536;

   // Width of the output_limit register field
   localparam int LIMIT_W = 17;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_DECODE_MODE  = 1'b0;
   localparam logic REG_OUTPUT_LIMIT = 1'b1;

   // Job queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One job: one or two result words caused by one input word
   typedef struct packed {
      logic       two;   // second word present (always carries data)
      logic [7:0] d0;    // first word, 0 for a bare end marker
      logic       has0;  // first word carries data
      logic [7:0] d1;    // second word
      logic       eom;   // job closes a message
      logic       err;   // decode error flag for the closing word
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- hdl/sbtc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbtc_front - word intake and classification
// Holds the message state, encodes or decodes each accepted word, applies
// the output limit and hands a job descriptor to the queue.
// ----------------------------------------------------------------------------
module sbtc_front #(
   parameter int MAX_OUTPUT = 65536,
   localparam int CNT_W = $clog2(MAX_OUTPUT + 1),
   localparam int LIM_W = (CNT_W > sbtc_pkg::LIMIT_W) ? CNT_W : sbtc_pkg::LIMIT_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 last_in,
   input  logic                 decode_mode,
   input  logic [LIM_W-1:0]     output_limit,
   input  logic                 clear,
   output logic                 job_push,
   output sbtc_pkg::job_type    job
);
   import sbtc_pkg::*;

   localparam int CW = LIM_W + 1;
   localparam logic [1:0] POS0 = 2'd0;
   localparam logic [1:0] POS1 = 2'd1;
   localparam logic [1:0] POS2 = 2'd2;
   localparam logic [1:0] POS3 = 2'd3;

   logic [7:0]       pend_ff, pend_in;
   logic [1:0]       phase_ff, phase_in;
   logic             err_ff, err_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             a_has, b_has, ok_a, ok_b;
   logic [7:0]       a_byte, b_byte, ch;
   logic [5:0]       made, rest;
   logic [LIM_W-1:0] lim_eff;
   logic [CW-1:0]    cnt_x, lim_x;

   always_comb begin
      pend_in  = pend_ff;
      phase_in = phase_ff;
      err_in   = err_ff;
      a_has    = 1'b0;
      b_has    = 1'b0;
      a_byte   = 8'd0;
      b_byte   = 8'd0;
      made     = 6'd0;
      rest     = 6'd0;
      ch       = in_byte - SYM_OFFSET;

      if (!decode_mode) begin
         // encode: three bytes -> four symbols, MSBs first
         case (phase_ff)
            POS1: begin
               made     = {pend_ff[5:4], in_byte[7:4]};
               rest     = {in_byte[3:0], 2'b00};
               phase_in = POS2;
               pend_in  = {2'b00, rest};
            end
            POS2: begin
               made     = {pend_ff[5:2], in_byte[7:6]};
               rest     = in_byte[5:0];
               phase_in = POS0;
               pend_in  = 8'd0;
               b_has    = 1'b1;
            end
            default: begin
               made     = in_byte[7:2];
               rest     = {in_byte[1:0], 4'b0000};
               phase_in = POS1;
               pend_in  = {2'b00, rest};
            end
         endcase
         a_has  = 1'b1;
         a_byte = {2'b00, made} + SYM_OFFSET;
         b_byte = {2'b00, rest} + SYM_OFFSET;
         // partial group flushed on the last byte
         if (last_in && (phase_in != POS0)) begin
            b_has  = 1'b1;
            b_byte = pend_in + SYM_OFFSET;
         end
      end else begin
         if (in_byte < SYM_OFFSET) begin
            err_in = 1'b1;
         end else if (!err_ff) begin
            case (phase_ff)
               POS0: begin
                  pend_in  = {ch[5:0], 2'b00};
                  phase_in = POS1;
               end
               POS1: begin
                  a_has    = 1'b1;
                  a_byte   = pend_ff | {6'd0, ch[5:4]};
                  pend_in  = {ch[3:0], 4'd0};
                  phase_in = POS2;
               end
               POS2: begin
                  a_has    = 1'b1;
                  a_byte   = pend_ff | {4'd0, ch[5:2]};
                  pend_in  = {ch[1:0], 6'd0};
                  phase_in = POS3;
               end
               default: begin
                  a_has    = 1'b1;
                  a_byte   = pend_ff | {2'd0, ch[5:0]};
                  pend_in  = 8'd0;
                  phase_in = POS0;
               end
            endcase
         end
      end

      // output limit, never above MAX_OUTPUT
      if (output_limit > LIM_W'(MAX_OUTPUT)) begin
         lim_eff = LIM_W'(MAX_OUTPUT);
      end else begin
         lim_eff = output_limit;
      end
      cnt_x = CW'(cnt_ff);
      lim_x = CW'(lim_eff);
      ok_a  = a_has && (cnt_x < lim_x);
      ok_b  = b_has && ok_a && ((cnt_x + CW'(1)) < lim_x);
      cnt_in = CNT_W'(cnt_x + CW'(ok_a) + CW'(ok_b));

      job.two  = ok_b;
      job.d0   = ok_a ? a_byte : 8'd0;
      job.has0 = ok_a;
      job.d1   = b_byte;
      job.eom  = last_in;
      job.err  = decode_mode & err_in;
      job_push = accept && (ok_a || last_in);
   end

   always_ff @(posedge clock) begin
      if (reset || clear || (accept && last_in)) begin
         pend_ff  <= 8'd0;
         phase_ff <= POS0;
         err_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else if (accept) begin
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
         err_ff   <= err_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- hdl/sbtc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbtc_queue - short job queue
// Register-based FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sbtc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  sbtc_pkg::job_type       wr_data,
   input  logic                    rd_en,
   output sbtc_pkg::job_type       rd_data,
   output sbtc_pkg::q_status_type  status
);
   import sbtc_pkg::*;

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_wr, do_rd;

   assign status.full  = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr   = wr_en && !status.full;
   assign do_rd   = rd_en && !status.empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hdl/sbtc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbtc_back - result sequencer
// Unpacks each job into one or two result words and holds them in the
// output register until popped.
// ----------------------------------------------------------------------------
module sbtc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sbtc_pkg::job_type       head,
   input  sbtc_pkg::q_status_type  q_status,
   output logic                    q_rd,
   input  logic                    pop,
   output logic                    empty,
   output logic [7:0]              out_byte,
   output logic                    has_data,
   output logic                    end_of_message,
   output logic                    decode_error
);
   import sbtc_pkg::*;

   logic       valid_ff, valid_in;
   logic       idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       has_ff, eom_ff, err_ff;
   logic       load, fin, sel_has;
   logic [7:0] sel_byte;

   always_comb begin
      if (!idx_ff) begin
         sel_byte = head.d0;
         sel_has  = head.has0;
         fin      = !head.two;
      end else begin
         sel_byte = head.d1;
         sel_has  = 1'b1;
         fin      = 1'b1;
      end
      load     = !q_status.empty && (!valid_ff || pop);
      q_rd     = load && fin;
      idx_in   = load ? !fin : idx_ff;
      valid_in = load || (valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= sel_byte;
         has_ff  <= sel_has;
         eom_ff  <= head.eom & fin;
         err_ff  <= head.err & fin;
      end
   end

   assign empty          = !valid_ff;
   assign out_byte       = byte_ff;
   assign has_data       = has_ff;
   assign end_of_message = eom_ff;
   assign decode_error   = err_ff;

endmodule

// ----- hdl/six_bit_text_codec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_bit_text_codec - printable six-bit byte stream codec
// Encodes bytes into offset six-bit symbols (3 bytes -> 4 symbols) or
// decodes them back, with an output cap per message and end markers.
// ----------------------------------------------------------------------------
// Usage: words go in through push/full and come out through pop/empty, one
// word per clock on each side while nothing stalls. An input word is taken
// in the cycle it is offered unless the four-entry job queue is full, and
// its results pass through the job queue and the output register to the
// result ports. The result port moves one word per cycle while words are
// popped, so a byte that yields two symbols (the third of a group, or any
// byte carrying a final flush) leaves as two words: sustained throughput is
// one input word per cycle for single-result words, and two-result words are
// held back by the output register. Set decode_mode (address 0) and
// output_limit (address 4) only while idle; writing decode_mode also clears
// the message in progress. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module six_bit_text_codec #(
   parameter int MAX_OUTPUT = sbtc_pkg::DEF_MAX_OUTPUT
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_last_in,
   // result channel
   input  logic                          pop,
   output logic                          empty,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_has_data,
   output logic                          rsp_end_of_message,
   output logic                          rsp_decode_error,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sbtc_pkg::CSR_AW-1:0]   paddr,
   input  logic [sbtc_pkg::CSR_DW-1:0]   pwdata,
   output logic [sbtc_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import sbtc_pkg::*;

   localparam int CNT_W = $clog2(MAX_OUTPUT + 1);
   localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   logic             decode_mode_ff;
   logic [LIM_W-1:0] output_limit_ff;
   logic             csr_wr, reg_sel, mode_clear, accept, job_push;
   job_type          job, head;
   q_status_type     q_status;
   logic             q_rd;

   // Register file: word address picks the register, low bits ignored
   assign pready     = 1'b1;
   assign reg_sel    = paddr[2];
   assign csr_wr     = psel && penable && pwrite && pready;
   assign mode_clear = csr_wr && (reg_sel == REG_DECODE_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff  <= 1'b0;
         output_limit_ff <= LIM_W'(MAX_OUTPUT);
      end else if (csr_wr) begin
         case (reg_sel)
            REG_DECODE_MODE:  decode_mode_ff  <= pwdata[0];
            REG_OUTPUT_LIMIT: output_limit_ff <= LIM_W'(pwdata[LIMIT_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DECODE_MODE:  prdata = CSR_DW'(decode_mode_ff);
         REG_OUTPUT_LIMIT: prdata = CSR_DW'(output_limit_ff);
         default:          prdata = '0;
      endcase
   end

   // Input side stalls only on a full job queue
   assign full   = q_status.full;
   assign accept = push && !full;

   sbtc_front #(
      .MAX_OUTPUT (MAX_OUTPUT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .last_in      (req_last_in),
      .decode_mode  (decode_mode_ff),
      .output_limit (output_limit_ff),
      .clear        (mode_clear),
      .job_push     (job_push),
      .job          (job)
   );

   sbtc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job),
      .rd_en   (q_rd),
      .rd_data (head),
      .status  (q_status)
   );

   sbtc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .q_rd           (q_rd),
      .pop            (pop),
      .empty          (empty),
      .out_byte       (rsp_out_byte),
      .has_data       (rsp_has_data),
      .end_of_message (rsp_end_of_message),
      .decode_error   (rsp_decode_error)
   );

endmodule

// ----- hdl/sbtc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbtc_checker - port-level checks for the codec
// Watches the result channel and configuration port of the top level.
// ----------------------------------------------------------------------------
module sbtc_checker (
   input logic       clock,
   input logic       reset,
   input logic       pop,
   input logic       empty,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_data,
   input logic       rsp_end_of_message,
   input logic       rsp_decode_error,
   input logic       pready
);

   // nothing waits on the result side right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result word present after reset");

   // a word not taken stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte)
                            && $stable(rsp_end_of_message)))
      else $error("stalled result word changed");

   // a bare marker only closes a message and carries a zero byte
   a_marker: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_has_data) |-> (rsp_end_of_message && (rsp_out_byte == 8'd0)))
      else $error("bare marker without end of message");

   // the error flag only rides on the closing word
   a_err_on_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_decode_error) |-> rsp_end_of_message)
      else $error("decode error on a word that does not close a message");

   a_ready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("configuration port not ready");

endmodule

bind six_bit_text_codec sbtc_checker u_sbtc_checker (.*);
